@@ rtl/sharpen_3x3_clamped_unit_assert.svh @@
// Assertion macros shared by the sharpening filter modules.
// Each macro expects signals named clk and rst_n in the module that uses it.
`ifndef SHARPEN_3X3_CLAMPED_UNIT_ASSERT_SVH
`define SHARPEN_3X3_CLAMPED_UNIT_ASSERT_SVH

// A condition that must hold at every clock edge outside reset.
`define SHP3_ASSERT_ALWAYS(name, cond, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define SHP3_ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define SHP3_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/shp3_pkg.sv @@
// Shared types and constants for the 3x3 sharpening filter.
// No dependencies; every other RTL module except shp3_queue imports this package.
package shp3_pkg;

    // Pixel and configuration widths.
    localparam int PIX_W      = 8;
    localparam int CFG_W      = 12;
    localparam int APB_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;
    localparam int DIM_MIN    = 3;

    // Default frame limits handed to the top level parameters.
    localparam int MAX_WIDTH_DEF  = 2048;
    localparam int MAX_HEIGHT_DEF = 2048;

    // Register reset values.
    localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = 12'd640;
    localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = 12'd480;

    // Register indexes, taken from the word address.
    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // Input item commands.
    localparam logic CMD_PIXEL = 1'b0;
    localparam logic CMD_DRAIN = 1'b1;

    // Queue depths between the front end, the back end and the output.
    localparam int MID_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    // One classified item passed from the front end to the back end.
    typedef struct packed {
        logic             drain;
        logic [PIX_W-1:0] pixel;
        logic             emit;
        logic             border;
        logic             last;
    } job_t;

    // One result waiting for the consumer.
    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } result_t;

endpackage

@@ rtl/shp3_queue.sv @@
// Small register-based FIFO used between the filter stages and at the output.
// Standalone; uses the assertion macro header only.
`include "sharpen_3x3_clamped_unit_assert.svh"

module shp3_queue #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    // Status flags come straight from the occupancy count.
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign rdata   = store_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    // Pointer and count updates.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Payload storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= wdata;
        end
    end

    `SHP3_ASSERT_IMPLIES(a_queue_no_overflow, push, !full, "push into a full queue")
    `SHP3_ASSERT_ALWAYS(a_queue_count_bound, count_reg <= CNT_W'(DEPTH), "queue count overrun")
    `SHP3_ASSERT_NEXT(a_queue_push_fills, do_push && !do_pop, !empty, "queue lost a pushed entry")

endmodule

@@ rtl/shp3_front.sv @@
// Front end of the sharpening filter: accepts items, tracks the raster position
// and classifies each item for the back end. Depends on shp3_pkg.
module shp3_front #(
    parameter int MAX_WIDTH  = 2048,
    parameter int MAX_HEIGHT = 2048
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [shp3_pkg::CFG_W-1:0]    frame_width,
    input  logic [shp3_pkg::CFG_W-1:0]    frame_height,
    input  logic                          push,
    input  logic                          cmd,
    input  logic [shp3_pkg::PIX_W-1:0]    pixel_in,
    input  logic                          q_full,
    output logic                          q_push,
    output logic [$clog2(MAX_WIDTH)-1:0]  q_addr,
    output shp3_pkg::job_t                q_job
);

    import shp3_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int PW = $clog2(MAX_WIDTH + 2);
    localparam int EW = (CFG_W > WW) ? CFG_W : WW;
    localparam int EH = (CFG_W > RW) ? CFG_W : RW;

    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [PW-1:0] pend_reg, pend_next;
    logic          drain_reg, drain_next;

    logic [EW-1:0] fw_ext, w_ext;
    logic [EH-1:0] fh_ext, h_ext;
    logic [WW-1:0] w;
    logic [RW-1:0] h;
    logic [CW-1:0] col_eff;
    logic [CW-1:0] col_inc;
    logic [RW-1:0] row_inc;
    logic          col_last;
    logic          emit_px;
    logic          interior;
    logic          accept;

    // Frame size in use, saturated to the supported range.
    always_comb
    begin
        fw_ext = EW'(frame_width);
        fh_ext = EH'(frame_height);
        if (fw_ext < EW'(DIM_MIN))
        begin
            w_ext = EW'(DIM_MIN);
        end
        else if (fw_ext > EW'(MAX_WIDTH))
        begin
            w_ext = EW'(MAX_WIDTH);
        end
        else
        begin
            w_ext = fw_ext;
        end
        if (fh_ext < EH'(DIM_MIN))
        begin
            h_ext = EH'(DIM_MIN);
        end
        else if (fh_ext > EH'(MAX_HEIGHT))
        begin
            h_ext = EH'(MAX_HEIGHT);
        end
        else
        begin
            h_ext = fh_ext;
        end
        w = w_ext[WW-1:0];
        h = h_ext[RW-1:0];
    end

    // A column beyond the current width counts as the last column.
    assign col_eff  = (WW'(col_reg) >= w) ? CW'(w - WW'(1)) : col_reg;
    assign col_last = (WW'(col_eff) == w - WW'(1));
    assign col_inc  = col_last ? '0 : col_eff + CW'(1);
    assign row_inc  = row_reg + RW'(1);
    assign emit_px  = (pend_reg >= PW'(w) + PW'(1));

    // The centre pixel of the window is interior when it is at least two
    // columns in and its row lies strictly inside the frame.
    assign interior = (col_eff >= CW'(2)) && (row_reg >= RW'(2))
                      && (row_reg <= h - RW'(1));

    assign accept = push && !q_full;
    assign q_addr = col_eff;

    // Classification and raster bookkeeping for each accepted transaction.
    always_comb
    begin
        col_next     = col_reg;
        row_next     = row_reg;
        pend_next    = pend_reg;
        drain_next   = drain_reg;
        q_push       = 1'b0;
        q_job.drain  = 1'b0;
        q_job.pixel  = pixel_in;
        q_job.emit   = 1'b0;
        q_job.border = 1'b1;
        q_job.last   = 1'b0;
        if (accept)
        begin
            case (cmd)
                CMD_PIXEL:
                begin
                    if (!drain_reg)
                    begin
                        q_push       = 1'b1;
                        q_job.emit   = emit_px;
                        q_job.border = !interior;
                        if (!emit_px)
                        begin
                            pend_next = pend_reg + PW'(1);
                        end
                        col_next = col_inc;
                        if (col_last)
                        begin
                            row_next = row_inc;
                            if (row_inc >= h)
                            begin
                                drain_next = 1'b1;
                            end
                        end
                    end
                end
                CMD_DRAIN:
                begin
                    if (drain_reg && (pend_reg != '0))
                    begin
                        q_push      = 1'b1;
                        q_job.drain = 1'b1;
                        q_job.emit  = 1'b1;
                        q_job.last  = (pend_reg == PW'(1));
                        pend_next   = pend_reg - PW'(1);
                        col_next    = col_inc;
                        if (pend_reg == PW'(1))
                        begin
                            drain_next = 1'b0;
                            row_next   = '0;
                            col_next   = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            row_reg   <= '0;
            pend_reg  <= '0;
            drain_reg <= 1'b0;
        end
        else
        begin
            col_reg   <= col_next;
            row_reg   <= row_next;
            pend_reg  <= pend_next;
            drain_reg <= drain_next;
        end
    end

endmodule

@@ rtl/shp3_back.sv @@
// Back end of the sharpening filter: line buffer memory, 3x3 window, kernel
// arithmetic and the output FIFO. Depends on shp3_pkg and shp3_queue.
`include "sharpen_3x3_clamped_unit_assert.svh"

module shp3_back #(
    parameter int MAX_WIDTH = 2048
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  logic [$clog2(MAX_WIDTH)-1:0]  q_addr,
    input  shp3_pkg::job_t                q_job,
    output logic                          q_pop,
    output logic                          empty,
    input  logic                          pop,
    output logic [shp3_pkg::PIX_W-1:0]    pixel_out,
    output logic                          frame_last
);

    import shp3_pkg::*;

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int CRW = $clog2(OUT_DEPTH + 1);

    // Both line buffers share one address: upper byte is the older row.
    logic [2*PIX_W-1:0] line_mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;
    logic [2*PIX_W-1:0] fwd_data_reg;
    logic               fwd_reg, fwd_next;

    logic               r_valid_reg;
    logic [CW-1:0]      r_addr_reg;
    job_t               r_job_reg;
    logic               x_valid_reg;
    job_t               x_job_reg;
    logic [PIX_W-1:0]   win_reg [3][3];
    logic [CRW-1:0]     credit_reg, credit_next;

    logic               issue;
    logic [2*PIX_W-1:0] pair_r;
    logic [PIX_W-1:0]   tap_old;
    logic [PIX_W-1:0]   tap_new;
    logic [PIX_W-1:0]   tap_bot;
    logic               wr_en;
    logic [2*PIX_W-1:0] wr_pair;

    logic [PIX_W-1:0]   center;
    logic [11:0]        ten_c;
    logic [11:0]        sum9;
    logic [12:0]        diff;
    logic [PIX_W-1:0]   sharp;
    result_t            res;
    logic               out_push;
    logic               out_full;
    logic               out_accept;
    logic               drop;
    logic [$bits(result_t)-1:0] out_bits;
    result_t            out_item;

    // Start an item only when the output FIFO has room for everything in flight.
    assign issue = !q_empty && (credit_reg < CRW'(OUT_DEPTH));
    assign q_pop = issue;

    // A write to the address being read in the same cycle is forwarded.
    assign pair_r   = fwd_reg ? fwd_data_reg : rd_data_reg;
    assign tap_old  = pair_r[2*PIX_W-1:PIX_W];
    assign tap_new  = pair_r[PIX_W-1:0];
    assign tap_bot  = r_job_reg.drain ? '0 : r_job_reg.pixel;
    assign wr_en    = r_valid_reg && !r_job_reg.drain;
    assign wr_pair  = {tap_new, r_job_reg.pixel};
    assign fwd_next = issue && wr_en && (q_addr == r_addr_reg);

    // Line buffer memory: read at issue, written in the following cycle.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            rd_data_reg <= line_mem[q_addr];
        end
        if (wr_en)
        begin
            line_mem[r_addr_reg] <= wr_pair;
        end
    end

    // Payload of the read and shift stages.
    always_ff @(posedge clk)
    begin
        if (issue)
        begin
            r_addr_reg   <= q_addr;
            r_job_reg    <= q_job;
            fwd_data_reg <= wr_pair;
        end
        if (r_valid_reg)
        begin
            x_job_reg <= r_job_reg;
        end
    end

    // Stage valids, forwarding flag and the 3x3 window.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            r_valid_reg <= 1'b0;
            x_valid_reg <= 1'b0;
            fwd_reg     <= 1'b0;
            credit_reg  <= '0;
            for (int i = 0; i < 3; i++)
            begin
                for (int j = 0; j < 3; j++)
                begin
                    win_reg[i][j] <= '0;
                end
            end
        end
        else
        begin
            r_valid_reg <= issue;
            x_valid_reg <= r_valid_reg;
            fwd_reg     <= fwd_next;
            credit_reg  <= credit_next;
            if (r_valid_reg)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    win_reg[i][0] <= win_reg[i][1];
                    win_reg[i][1] <= win_reg[i][2];
                end
                win_reg[0][2] <= tap_old;
                win_reg[1][2] <= tap_new;
                win_reg[2][2] <= tap_bot;
            end
        end
    end

    // Kernel: ten times the centre minus all nine taps, clamped to a byte.
    always_comb
    begin
        center = win_reg[1][1];
        ten_c  = (12'(center) << 3) + (12'(center) << 1);
        sum9   = '0;
        for (int i = 0; i < 3; i++)
        begin
            for (int j = 0; j < 3; j++)
            begin
                sum9 = sum9 + 12'(win_reg[i][j]);
            end
        end
        diff = {1'b0, ten_c} - {1'b0, sum9};
        if (diff[12])
        begin
            sharp = '0;
        end
        else if (diff[11:0] > 12'd255)
        begin
            sharp = 8'd255;
        end
        else
        begin
            sharp = diff[PIX_W-1:0];
        end
        res.pixel = x_job_reg.border ? center : sharp;
        res.last  = x_job_reg.last;
    end

    assign out_push   = x_valid_reg && x_job_reg.emit;
    assign drop       = x_valid_reg && !x_job_reg.emit;
    assign out_accept = pop && !empty;

    // Credits count items in flight plus results held in the output FIFO.
    assign credit_next = credit_reg + CRW'(issue) - CRW'(out_accept) - CRW'(drop);

    shp3_queue #(
        .WIDTH ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (out_push),
        .wdata (res),
        .full  (out_full),
        .pop   (pop),
        .rdata (out_bits),
        .empty (empty)
    );

    assign out_item   = out_bits;
    assign pixel_out  = out_item.pixel;
    assign frame_last = out_item.last;

    `SHP3_ASSERT_ALWAYS(a_credit_bound, credit_reg <= CRW'(OUT_DEPTH), "credit count overrun")
    `SHP3_ASSERT_IMPLIES(a_out_room, out_push, !out_full, "result pushed into full FIFO")
    `SHP3_ASSERT_NEXT(a_fwd_follows, fwd_next, r_valid_reg && fwd_reg, "forward without item")

endmodule

@@ rtl/sharpen_3x3_clamped_unit.sv @@
// Top level of the 3x3 Laplacian sharpening filter: configuration registers,
// front end, classification queue and back end. Depends on shp3_pkg,
// shp3_front, shp3_queue and shp3_back.
//
// Channel   Direction  Handshake                     Payload
// config    in/out     psel, penable, pwrite, pready paddr, pwdata, prdata
// pixels    in         push / full                   cmd, pixel_in
// results   out        empty / pop                   pixel_out, frame_last
//
// One item is accepted per clock cycle when neither side stalls.
// A result is written to the output FIFO after its item has passed the
// queue, the line buffer memory read and the window shift.
// The line buffer memory has one read and one write port; the item read and
// the previous item's write share a cycle, with forwarding on an address match.
// Reset clears the raster position, the window and all queues; the line
// buffer memory holds undefined data until written and needs no clearing pass.
// A stalled consumer fills the output FIFO, then the middle queue, then full.
module sharpen_3x3_clamped_unit #(
    parameter int MAX_WIDTH  = shp3_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = shp3_pkg::MAX_HEIGHT_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [shp3_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [shp3_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [shp3_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    input  logic                              push,
    output logic                              full,
    input  logic                              cmd,
    input  logic [shp3_pkg::PIX_W-1:0]        pixel_in,
    output logic                              empty,
    input  logic                              pop,
    output logic [shp3_pkg::PIX_W-1:0]        pixel_out,
    output logic                              frame_last
);

    import shp3_pkg::*;

    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int MID_W = CW + $bits(job_t);

    logic [CFG_W-1:0] frame_width_reg, frame_width_next;
    logic [CFG_W-1:0] frame_height_reg, frame_height_next;
    logic             cfg_write;
    logic             reg_idx;

    logic             f_push;
    logic [CW-1:0]    f_addr;
    job_t             f_job;
    logic             mid_full;
    logic             mid_empty;
    logic             mid_pop;
    logic [MID_W-1:0] mid_rdata;
    logic [CW-1:0]    b_addr;
    job_t             b_job;

    // Configuration port: zero wait states, word index from the address.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[2];

    always_comb
    begin
        frame_width_next  = frame_width_reg;
        frame_height_next = frame_height_reg;
        prdata            = '0;
        case (reg_idx)
            REG_FRAME_WIDTH:
            begin
                prdata = APB_DATA_W'(frame_width_reg);
                if (cfg_write)
                begin
                    frame_width_next = pwdata[CFG_W-1:0];
                end
            end
            REG_FRAME_HEIGHT:
            begin
                prdata = APB_DATA_W'(frame_height_reg);
                if (cfg_write)
                begin
                    frame_height_next = pwdata[CFG_W-1:0];
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
        end
        else
        begin
            frame_width_reg  <= frame_width_next;
            frame_height_reg <= frame_height_next;
        end
    end

    // Input side stalls only when the classification queue is full.
    assign full = mid_full;

    shp3_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .push         (push),
        .cmd          (cmd),
        .pixel_in     (pixel_in),
        .q_full       (mid_full),
        .q_push       (f_push),
        .q_addr       (f_addr),
        .q_job        (f_job)
    );

    shp3_queue #(
        .WIDTH (MID_W),
        .DEPTH (MID_DEPTH)
    ) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_push),
        .wdata ({f_addr, f_job}),
        .full  (mid_full),
        .pop   (mid_pop),
        .rdata (mid_rdata),
        .empty (mid_empty)
    );

    assign b_addr = mid_rdata[MID_W-1:$bits(job_t)];
    assign b_job  = mid_rdata[$bits(job_t)-1:0];

    shp3_back #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_empty    (mid_empty),
        .q_addr     (b_addr),
        .q_job      (b_job),
        .q_pop      (mid_pop),
        .empty      (empty),
        .pop        (pop),
        .pixel_out  (pixel_out),
        .frame_last (frame_last)
    );

endmodule

@@ verif/sharpen_3x3_clamped_unit_tb.sv @@
// Self-checking testbench for the 3x3 sharpening filter top level.
// Depends on shp3_pkg and the sharpen_3x3_clamped_unit RTL. It predicts every
// result with its own line buffer model and checks the output queue against it.
module sharpen_3x3_clamped_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import shp3_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int MAX_W         = MAX_WIDTH_DEF;
    localparam int MAX_H         = MAX_HEIGHT_DEF;
    localparam int LIMIT_CYCLES  = 500_000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_ITEMS  = 420;
    localparam int REPORT_CAP    = 50;

    localparam logic [CFG_ADDR_W-1:0] WIDTH_ADDR  = CFG_ADDR_W'(4 * REG_FRAME_WIDTH);
    localparam logic [CFG_ADDR_W-1:0] HEIGHT_ADDR = CFG_ADDR_W'(4 * REG_FRAME_HEIGHT);

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  push;
    logic                  full;
    logic                  cmd;
    logic [PIX_W-1:0]      pixel_in;
    logic                  empty;
    logic                  pop;
    logic [PIX_W-1:0]      pixel_out;
    logic                  frame_last;

    // Filter model state: registers, line buffers, window and raster position.
    logic [CFG_W-1:0] cfg_width_q;
    logic [CFG_W-1:0] cfg_height_q;
    logic [PIX_W-1:0] row_older [MAX_W];
    logic [PIX_W-1:0] row_newer [MAX_W];
    logic [PIX_W-1:0] win [3][3];
    int               col_pos;
    int               row_pos;
    int               in_flight;
    bit               drain_phase;

    // Sharpened pixels predicted but not yet seen at the output.
    result_t awaited_pixels [$];

    int error_count     = 0;
    int items_in        = 0;
    int results_checked = 0;
    int frames_sent     = 0;
    int cycle_count     = 0;
    int tx_idle_max     = 12;
    int rx_idle_max     = 12;
    int hold_cycles     = 0;

    sharpen_3x3_clamped_unit uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .push       (push),
        .full       (full),
        .cmd        (cmd),
        .pixel_in   (pixel_in),
        .empty      (empty),
        .pop        (pop),
        .pixel_out  (pixel_out),
        .frame_last (frame_last)
    );

    // Free-running clock.
    always #HALF_PERIOD clk = ~clk;

    // Model state after reset.
    function automatic void reset_model();
        cfg_width_q  = FRAME_WIDTH_RST;
        cfg_height_q = FRAME_HEIGHT_RST;
        for (int i = 0; i < MAX_W; i++)
        begin
            row_older[i] = '0;
            row_newer[i] = '0;
        end
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                win[r][c] = '0;
            end
        end
        col_pos     = 0;
        row_pos     = 0;
        in_flight   = 0;
        drain_phase = 1'b0;
    endfunction

    // Frame dimensions saturate to 3..limit when used.
    function automatic int clamp_dim(input int v, input int hi);
        if (v < DIM_MIN)
            return DIM_MIN;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Shift the window one column left and load a new right column.
    function automatic void shift_window(input logic [PIX_W-1:0] top,
                                         input logic [PIX_W-1:0] centre_row,
                                         input logic [PIX_W-1:0] bottom);
        for (int r = 0; r < 3; r++)
        begin
            win[r][0] = win[r][1];
            win[r][1] = win[r][2];
        end
        win[0][2] = top;
        win[1][2] = centre_row;
        win[2][2] = bottom;
    endfunction

    // Laplacian kernel: nine times the centre minus the eight neighbours.
    function automatic logic [PIX_W-1:0] laplace_centre();
        int sum;
        sum = 10 * int'(win[1][1]);
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                sum -= int'(win[r][c]);
            end
        end
        if (sum > 255)
            sum = 255;
        if (sum < 0)
            sum = 0;
        return PIX_W'(sum);
    endfunction

    // Advance the model by one accepted item; returns 1 when it yields a pixel.
    function automatic bit filter_step(input logic item_cmd, input logic [PIX_W-1:0] pix,
                                       output result_t res);
        int               w;
        int               h;
        int               cc;
        int               pr;
        int               pc;
        bit               emit;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        w   = clamp_dim(int'(cfg_width_q), MAX_W);
        h   = clamp_dim(int'(cfg_height_q), MAX_H);
        cc  = col_pos;
        res = '0;
        if (cc >= w)
            cc = w - 1;

        if (item_cmd == CMD_PIXEL)
        begin
            // Pixels that arrive while the frame is draining are dropped.
            if (drain_phase)
                return 1'b0;
            up  = row_older[cc];
            mid = row_newer[cc];
            shift_window(up, mid, pix);
            row_older[cc] = mid;
            row_newer[cc] = pix;
            emit = in_flight >= w + 1;
            if (!emit)
                in_flight++;
            // Position of the pixel that now sits at the window centre.
            if (cc >= 1)
            begin
                pr = row_pos - 1;
                pc = cc - 1;
            end
            else
            begin
                pr = row_pos - 2;
                pc = w - 1;
            end
            cc++;
            if (cc >= w)
            begin
                cc = 0;
                row_pos++;
                if (row_pos >= h)
                    drain_phase = 1'b1;
            end
            col_pos = cc;
            if (!emit)
                return 1'b0;
            if (pr >= 1 && pr <= h - 2 && pc >= 1 && pc <= w - 2)
                res.pixel = laplace_centre();
            else
                res.pixel = win[1][1];
            res.last = 1'b0;
            return 1'b1;
        end

        // Drain items only count once the whole frame is in.
        if (!drain_phase || in_flight == 0)
            return 1'b0;
        shift_window(row_older[cc], row_newer[cc], '0);
        res.pixel = win[1][1];
        res.last  = 1'b0;
        in_flight--;
        cc++;
        if (cc >= w)
            cc = 0;
        col_pos = cc;
        if (in_flight == 0)
        begin
            res.last    = 1'b1;
            drain_phase = 1'b0;
            row_pos     = 0;
            col_pos     = 0;
        end
        return 1'b1;
    endfunction

    function automatic logic [PIX_W-1:0] pick_pixel();
        case ($urandom_range(7, 0))
            0:       return '0;
            1:       return '1;
            default: return PIX_W'($urandom);
        endcase
    endfunction

    function automatic int pick_idle();
        case ($urandom_range(4, 0))
            0:       return 0;
            1:       return 3;
            default: return 12;
        endcase
    endfunction

    // Mostly small sizes, sometimes medium, sometimes below the legal range.
    function automatic logic [CFG_W-1:0] pick_dim(input int typical_hi);
        int r;
        r = $urandom_range(99, 0);
        if (r < 8)
            return CFG_W'($urandom_range(2, 0));
        if (r < 25)
            return CFG_W'($urandom_range(typical_hi * 3, typical_hi + 1));
        return CFG_W'($urandom_range(typical_hi, DIM_MIN));
    endfunction

    function automatic void log_mismatch(input string field, input logic [PIX_W-1:0] want_v,
                                         input logic [PIX_W-1:0] got_v);
        error_count++;
        if (error_count <= REPORT_CAP)
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want_v, got_v);
    endfunction

    // One register write transaction: setup cycle, then access cycle.
    task automatic apb_write(input logic [CFG_ADDR_W-1:0] addr, input logic [CFG_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        word              = APB_DATA_W'($urandom);
        word[CFG_W-1:0]   = value;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == WIDTH_ADDR)
            cfg_width_q = value;
        else
            cfg_height_q = value;
    endtask

    // Offer one input transaction after a random gap and wait until it is taken.
    task automatic send_item(input logic item_cmd, input logic [PIX_W-1:0] pix);
        int      gap;
        result_t res;
        gap = $urandom_range(tx_idle_max, 0);
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push     <= 1'b1;
        cmd      <= item_cmd;
        pixel_in <= pix;
        do @(posedge clk); while (full);
        items_in++;
        if (filter_step(item_cmd, pix, res))
            awaited_pixels.push_back(res);
    endtask

    // Stop offering input until every predicted pixel has come out.
    task automatic wait_results_done();
        push <= 1'b0;
        @(posedge clk);
        while (awaited_pixels.size() != 0)
            @(posedge clk);
    endtask

    // Results done, then enough cycles for items with no result to clear the pipe.
    task automatic wait_block_idle();
        wait_results_done();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_frame(input logic [CFG_W-1:0] w_raw, input logic [CFG_W-1:0] h_raw);
        wait_block_idle();
        apb_write(WIDTH_ADDR, w_raw);
        apb_write(HEIGHT_ADDR, h_raw);
    endtask

    // One full frame of pixels and its drain items, with optional ignored noise.
    task automatic send_frame(input int noise_pct, input int pause_at);
        int w;
        int h;
        w = clamp_dim(int'(cfg_width_q), MAX_W);
        h = clamp_dim(int'(cfg_height_q), MAX_H);
        frames_sent++;
        for (int i = 0; i < w * h; i++)
        begin
            if (i == pause_at)
                wait_results_done();
            if ($urandom_range(99, 0) < noise_pct)
                send_item(CMD_DRAIN, PIX_W'($urandom));
            send_item(CMD_PIXEL, pick_pixel());
        end
        for (int i = 0; i <= w; i++)
        begin
            if ($urandom_range(99, 0) < noise_pct)
                send_item(CMD_PIXEL, pick_pixel());
            send_item(CMD_DRAIN, PIX_W'($urandom));
        end
        if ($urandom_range(99, 0) < noise_pct)
            send_item(CMD_DRAIN, PIX_W'($urandom));
    endtask

    // Smallest frames with both clamp limits, plus drains and pixels that are ignored.
    task automatic test_clamp_extremes();
        send_item(CMD_DRAIN, 8'hA5);
        send_item(CMD_DRAIN, 8'h5A);
        set_frame(12'd3, 12'd3);
        // Dark centre in a white frame clamps to zero; a drain mid-frame is ignored.
        for (int i = 0; i < 9; i++)
        begin
            if (i == 5)
                send_item(CMD_DRAIN, 8'hFF);
            send_item(CMD_PIXEL, (i == 4) ? 8'h00 : 8'hFF);
        end
        for (int i = 0; i < 4; i++)
            send_item(CMD_DRAIN, 8'h00);
        // White centre in a dark frame clamps to 255; a pixel while draining is ignored.
        for (int i = 0; i < 9; i++)
            send_item(CMD_PIXEL, (i == 4) ? 8'hFF : 8'h00);
        send_item(CMD_PIXEL, 8'h81);
        for (int i = 0; i < 4; i++)
            send_item(CMD_DRAIN, 8'hFF);
        send_item(CMD_DRAIN, 8'h3C);
        frames_sent += 2;
    endtask

    // Register values below the legal range fall back to the smallest frame.
    task automatic test_size_extremes();
        tx_idle_max = 0;
        rx_idle_max = 0;
        set_frame(12'h000, 12'h002);
        send_frame(0, -1);
        set_frame(12'h001, 12'h000);
        send_frame(0, -1);
        tx_idle_max = 12;
        rx_idle_max = 12;
    endtask

    // The consumer holds off long enough for the block to fill and assert full.
    task automatic test_output_stall();
        set_frame(12'd10, 12'd6);
        tx_idle_max = 0;
        hold_cycles = 400;
        send_frame(0, -1);
        tx_idle_max = 12;
    endtask

    // The producer stops mid-frame until every predicted pixel has come out.
    task automatic test_input_pause();
        set_frame(12'd7, 12'd5);
        tx_idle_max = 3;
        send_frame(0, 20);
        tx_idle_max = 12;
    endtask

    // Random frame sizes, idle patterns and ignored noise items.
    task automatic test_random_frames();
        int  sent;
        int  w;
        int  h;
        bit  keep;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            keep        = (sent > 0) && ($urandom_range(1, 0) == 1);
            tx_idle_max = pick_idle();
            rx_idle_max = pick_idle();
            if (!keep)
                set_frame(pick_dim(12), pick_dim(8));
            w = clamp_dim(int'(cfg_width_q), MAX_W);
            h = clamp_dim(int'(cfg_height_q), MAX_H);
            sent += w * h + w + 1;
            send_frame(5, ($urandom_range(3, 0) == 0) ? int'($urandom_range(30, 1)) : -1);
        end
    endtask

    // Result side: random pop gaps, long hold-offs on request, and checking.
    initial
    begin : result_sink
        int      gap;
        result_t want;
        pop = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = $urandom_range(rx_idle_max, 0);
            if (gap > 0 || hold_cycles > 0)
            begin
                pop <= 1'b0;
                repeat (gap) @(posedge clk);
                while (hold_cycles > 0)
                begin
                    @(posedge clk);
                    hold_cycles--;
                end
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
            results_checked++;
            if (awaited_pixels.size() == 0)
            begin
                error_count++;
                if (error_count <= REPORT_CAP)
                    $display("%0t: result with none expected, actual pixel_out %0d frame_last %0b",
                             $time, pixel_out, frame_last);
            end
            else
            begin
                want = awaited_pixels.pop_front();
                if (pixel_out !== want.pixel)
                    log_mismatch("pixel_out", want.pixel, pixel_out);
                if (frame_last !== want.last)
                    log_mismatch("frame_last", PIX_W'(want.last), PIX_W'(frame_last));
            end
        end
    end

    // Watchdog on the total run length.
    initial
    begin : watchdog
        while (cycle_count < LIMIT_CYCLES)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Timeout after %0d cycles, %0d results still expected",
                 cycle_count, awaited_pixels.size());
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Reset, the test sequence and the final verdict.
    initial
    begin
        rst_n    = 1'b0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        push     = 1'b0;
        cmd      = CMD_PIXEL;
        pixel_in = '0;
        reset_model();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        test_clamp_extremes();
        test_size_extremes();
        test_output_stall();
        test_input_pause();
        test_random_frames();

        rx_idle_max = 0;
        wait_block_idle();
        $display("Ran %0d frames of assorted sizes, some set below range: %0d input transactions,",
                 frames_sent, items_in);
        $display("%0d results checked, with output stalls, input pauses and ignored items.",
                 results_checked);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
